### src/oal_pkg.sv
package oal_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int DATA_W       = 32;
  localparam int REQ_W        = 3;

  typedef logic [REQ_W-1:0] req_t;

  localparam req_t REQ_INSERT      = 3'd0;
  localparam req_t REQ_APPEND      = 3'd1;
  localparam req_t REQ_REMOVE      = 3'd2;
  localparam req_t REQ_REMOVE_TAIL = 3'd3;
  localparam req_t REQ_SEARCH      = 3'd4;

  typedef logic [1:0] status_t;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_FULL  = 2'd1;
  localparam status_t ST_EMPTY = 2'd2;
  localparam status_t ST_RANGE = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic scan_init;
    logic scan_read;
    logic wr_shift;
    logic found_set;
    logic finish;
    logic result_load;
  } cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic    need_up;
    logic    need_down;
    logic    need_search;
    logic    last;
    logic    match;
  } stat_t;

endpackage

### src/ordered_array_list.sv
// Ordered list of up to CAPACITY signed 32-bit values held in a single-port-write
// RAM, with a fill count. Each input transaction carries req_type, value and
// position, and produces exactly one output transaction with status,
// found_index and element_count (the count after the request).
// Both channels use valid/ready. One request is in flight at a time: in_ready
// is high only while the controller is idle.
// Append, tail remove, rejected requests and requests that move no entries
// go from decode straight to the count update. A positional insert or remove
// shifts the entries it moves through the RAM, one RAM read and one RAM
// write per cycle. A search reads entries from index 0 and stops at the first
// match; a miss reads every entry, and a search of an empty list reads none.
// A new request can be accepted in the cycle after the previous result has
// been loaded into the output register.
// The output register parts the two sides: a stalled receiver holds the
// current result stable, and the next request is already accepted and
// worked on; it waits in its final state until the output register frees up.
// Reset clears the count and the handshake state. The RAM is not cleared;
// only entries below the count are ever read.
module ordered_array_list #(
  parameter int CAPACITY = oal_pkg::CAPACITY_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [oal_pkg::REQ_W-1:0]         req_type,
  input  logic signed [oal_pkg::DATA_W-1:0] value,
  input  logic [$clog2(CAPACITY+1)-1:0]     position,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        status,
  output logic signed [$clog2(CAPACITY):0]  found_index,
  output logic [$clog2(CAPACITY+1)-1:0]     element_count
);

  // Command and status groups between the sequencer and the datapath.
  oal_pkg::cmd_t  cmd;
  oal_pkg::stat_t stat;

  // The controller walks each transaction through decode, the optional
  // shift or search scan, the count update and the result load.
  oal_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // The datapath owns the entry RAM, the count, the scan pointer, the
  // comparator and the output register.
  oal_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .req_type      (req_type),
    .value         (value),
    .position      (position),
    .cmd           (cmd),
    .stat          (stat),
    .status        (status),
    .found_index   (found_index),
    .element_count (element_count)
  );

endmodule

### src/oal_datapath.sv
module oal_datapath #(
  parameter int CAPACITY = oal_pkg::CAPACITY_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic [oal_pkg::REQ_W-1:0]             req_type,
  input  logic signed [oal_pkg::DATA_W-1:0]     value,
  input  logic [$clog2(CAPACITY+1)-1:0]         position,
  input  oal_pkg::cmd_t                         cmd,
  output oal_pkg::stat_t                        stat,
  output logic [1:0]                            status,
  output logic signed [$clog2(CAPACITY):0]      found_index,
  output logic [$clog2(CAPACITY+1)-1:0]         element_count
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int FW = AW + 1;

  logic [oal_pkg::DATA_W-1:0] mem [CAPACITY];

  oal_pkg::req_t              req_q;
  logic [oal_pkg::DATA_W-1:0] val_q;
  logic [CW-1:0]              pos_q;
  logic [CW-1:0]              count;
  logic [AW-1:0]              ptr;
  logic [AW-1:0]              rd_addr;
  logic                       rd_pend;
  logic [oal_pkg::DATA_W-1:0] rdata;
  logic signed [FW-1:0]       found_q;
  oal_pkg::status_t           code_q;

  oal_pkg::status_t           code;
  logic                       full;
  logic                       empty;
  logic [CW-1:0]              cnt_m1;
  logic                       up;
  logic                       down;
  logic                       srch;
  logic                       put;
  logic                       dec;
  logic [AW-1:0]              put_addr;
  logic [AW-1:0]              shift_addr;
  logic                       last;
  logic                       match;
  logic                       we;
  logic [AW-1:0]              wa;
  logic [oal_pkg::DATA_W-1:0] wd;

  assign full   = (count == CW'(CAPACITY));
  assign empty  = (count == '0);
  assign cnt_m1 = count - CW'(1);

  // Request decode against the current fill level.
  always_comb begin
    code = oal_pkg::ST_OK;
    up   = 1'b0;
    down = 1'b0;
    srch = 1'b0;
    put  = 1'b0;
    dec  = 1'b0;
    case (req_q)
      oal_pkg::REQ_INSERT: begin
        if (full) begin
          code = oal_pkg::ST_FULL;
        end else if (pos_q > count) begin
          code = oal_pkg::ST_RANGE;
        end else begin
          put = 1'b1;
          up  = (pos_q != count);
        end
      end
      oal_pkg::REQ_APPEND: begin
        if (full) begin
          code = oal_pkg::ST_FULL;
        end else begin
          put = 1'b1;
        end
      end
      oal_pkg::REQ_REMOVE: begin
        if (empty) begin
          code = oal_pkg::ST_EMPTY;
        end else if (pos_q >= count) begin
          code = oal_pkg::ST_RANGE;
        end else begin
          dec  = 1'b1;
          down = (pos_q != cnt_m1);
        end
      end
      oal_pkg::REQ_REMOVE_TAIL: begin
        if (empty) begin
          code = oal_pkg::ST_EMPTY;
        end else begin
          dec = 1'b1;
        end
      end
      oal_pkg::REQ_SEARCH: begin
        srch = !empty;
      end
      default: begin
      end
    endcase
  end

  assign put_addr   = (req_q == oal_pkg::REQ_APPEND) ? count[AW-1:0] : pos_q[AW-1:0];
  assign shift_addr = up ? (rd_addr + AW'(1)) : (rd_addr - AW'(1));
  assign last       = up ? (ptr == pos_q[AW-1:0]) : (ptr == cnt_m1[AW-1:0]);
  assign match      = rd_pend && (rdata == val_q);

  assign we = (cmd.wr_shift && rd_pend) || (cmd.finish && put);
  assign wa = cmd.finish ? put_addr : shift_addr;
  assign wd = cmd.finish ? val_q : rdata;

  assign stat.need_up     = up;
  assign stat.need_down   = down;
  assign stat.need_search = srch;
  assign stat.last        = last;
  assign stat.match       = match;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (cmd.scan_read) begin
      rdata <= mem[ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      rd_pend <= 1'b0;
    end else begin
      if (cmd.finish && put) begin
        count <= count + CW'(1);
      end else if (cmd.finish && dec) begin
        count <= cnt_m1;
      end
      if (cmd.scan_init) begin
        rd_pend <= 1'b0;
      end else if (cmd.scan_read) begin
        rd_pend <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q   <= req_type;
      val_q   <= value;
      pos_q   <= position;
      found_q <= (req_type == oal_pkg::REQ_SEARCH) ? '1 : '0;
    end
    if (cmd.scan_init) begin
      if (up) begin
        ptr <= cnt_m1[AW-1:0];
      end else if (down) begin
        ptr <= pos_q[AW-1:0] + AW'(1);
      end else begin
        ptr <= '0;
      end
    end else if (cmd.scan_read) begin
      ptr <= up ? (ptr - AW'(1)) : (ptr + AW'(1));
    end
    if (cmd.scan_read) begin
      rd_addr <= ptr;
    end
    if (cmd.found_set) begin
      found_q <= {1'b0, rd_addr};
    end
    if (cmd.finish) begin
      code_q <= code;
    end
    if (cmd.result_load) begin
      status        <= code_q;
      found_index   <= found_q;
      element_count <= count;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("element count above capacity");

  a_error_keeps_count: assert property (@(posedge clk) disable iff (rst)
    (cmd.finish && (code != oal_pkg::ST_OK)) |=> (count == $past(count)))
    else $error("rejected request changed the count");

  a_found_on_match: assert property (@(posedge clk) disable iff (rst)
    cmd.found_set |-> match)
    else $error("search index captured without a match");

endmodule

### src/oal_ctrl.sv
module oal_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  oal_pkg::stat_t stat,
  output oal_pkg::cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_DRAIN,
    S_FINISH,
    S_RESULT
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat.need_up || stat.need_down || stat.need_search) begin
          cmd.scan_init = 1'b1;
          state_next    = S_SCAN;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_SCAN: begin
        cmd.scan_read = 1'b1;
        if (stat.need_search) begin
          if (stat.match) begin
            cmd.found_set = 1'b1;
            state_next    = S_FINISH;
          end else if (stat.last) begin
            state_next = S_DRAIN;
          end
        end else begin
          cmd.wr_shift = 1'b1;
          if (stat.last) begin
            state_next = S_DRAIN;
          end
        end
      end
      S_DRAIN: begin
        if (stat.need_search) begin
          cmd.found_set = stat.match;
        end else begin
          cmd.wr_shift = 1'b1;
        end
        state_next = S_FINISH;
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_next = S_RESULT;
      end
      S_RESULT: begin
        if (!out_valid || out_ready) begin
          cmd.result_load = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.result_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second request taken while one is in flight");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.result_load |-> (!out_valid || out_ready))
    else $error("result register overwritten before it was taken");

  a_no_shift_in_search: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_shift |-> !stat.need_search)
    else $error("entry shift issued during a search");

endmodule
